@@ sv/asf_pkg.sv @@
`timescale 1ns / 1ps
package asf_pkg;

  // sample format register codes
  localparam logic [3:0] FMT_I16_LE     = 4'd0;
  localparam logic [3:0] FMT_I24_LE     = 4'd1;
  localparam logic [3:0] FMT_I32_LE     = 4'd2;
  localparam logic [3:0] FMT_F32_LE     = 4'd3;
  localparam logic [3:0] FMT_F64_LE     = 4'd4;
  localparam logic [3:0] FMT_I24IN32_LE = 4'd5;
  localparam logic [3:0] FMT_BE_FIRST   = 4'd6;
  localparam logic [3:0] FMT_UNKNOWN    = 4'd12;
  localparam logic [3:0] FMT_RESET      = FMT_F32_LE;

  // encoding kind after endianness is stripped
  typedef enum logic [2:0] {
    KIND_I16     = 3'd0,
    KIND_I24     = 3'd1,
    KIND_I32     = 3'd2,
    KIND_F32     = 3'd3,
    KIND_F64     = 3'd4,
    KIND_I24IN32 = 3'd5
  } kind_t;

  // integer full-scale values 2^(n-1)-1
  localparam logic [30:0] SCALE_I16 = 31'd32767;
  localparam logic [30:0] SCALE_I24 = 31'd8388607;
  localparam logic [30:0] SCALE_I32 = 31'd2147483647;

  // float32 constants
  localparam logic [30:0] F32_ONE_MAG = 31'h3F80_0000;
  localparam logic [31:0] F32_POS_ONE = 32'h3F80_0000;

  // float32 to float64 exponent rebias, and denormal rebias
  localparam logic [10:0] F64_REBIAS     = 11'd896;
  localparam logic [10:0] F64_DENORM_EXP = 11'd874;

  // result item
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
  } result_t;

  // reverse the low n bytes of a word
  function automatic logic [63:0] reverse_bytes(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    r = '0;
    unique case (n)
      4'd2:    r = {48'd0, v[7:0], v[15:8]};
      4'd3:    r = {40'd0, v[7:0], v[15:8], v[23:16]};
      4'd4:    r = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
      4'd8:    r = {v[7:0], v[15:8], v[23:16], v[31:24],
                    v[39:32], v[47:40], v[55:48], v[63:56]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

@@ sv/asf_convert.sv @@
`timescale 1ns / 1ps
module asf_convert (
  input  logic [31:0]          sample_bits,
  input  logic [3:0]           sample_format,
  output asf_pkg::result_t     result
);

  logic        is_nan;
  logic        mag_ge1;
  logic [31:0] c;
  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic        be;
  logic        unknown;
  asf_pkg::kind_t kind;
  logic [30:0] scale;
  logic [54:0] prod;
  logic [55:0] rnd;
  logic        inc;
  logic        int_zero;
  logic [5:0]  shm1;
  logic [55:0] q;
  logic [31:0] mag;
  logic [31:0] ival;
  logic [4:0]  lead;
  logic [52:0] dn_tmp;
  logic [63:0] f64;
  logic [63:0] val;
  logic [3:0]  cnt;

  // clamp to [-1,1], nan goes to +1
  assign is_nan  = (&sample_bits[30:23]) && (|sample_bits[22:0]);
  assign mag_ge1 = sample_bits[30:0] >= asf_pkg::F32_ONE_MAG;
  always_comb begin
    if (is_nan) begin
      c = asf_pkg::F32_POS_ONE;
    end else if (mag_ge1) begin
      c = {sample_bits[31], asf_pkg::F32_ONE_MAG};
    end else begin
      c = sample_bits;
    end
  end
  assign sgn = c[31];
  assign ex  = c[30:23];
  assign fr  = c[22:0];

  // format decode
  assign unknown = sample_format >= asf_pkg::FMT_UNKNOWN;
  assign be      = !unknown && (sample_format >= asf_pkg::FMT_BE_FIRST);
  always_comb begin
    if (be) begin
      kind = asf_pkg::kind_t'(3'(sample_format - asf_pkg::FMT_BE_FIRST));
    end else if (unknown) begin
      kind = asf_pkg::KIND_F32;
    end else begin
      kind = asf_pkg::kind_t'(sample_format[2:0]);
    end
  end

  always_comb begin
    unique case (kind)
      asf_pkg::KIND_I16: scale = asf_pkg::SCALE_I16;
      asf_pkg::KIND_I32: scale = asf_pkg::SCALE_I32;
      default:           scale = asf_pkg::SCALE_I24;
    endcase
  end

  // scale product; denormals round to zero so the hidden bit is always set
  assign prod = 55'({1'b1, fr}) * 55'(scale);

  // round product to 53 significant bits, nearest-even
  always_comb begin
    inc = 1'b0;
    if (prod[54]) begin
      inc = prod[1] && (prod[0] || prod[2]);
      rnd = (56'(prod[54:2]) + 56'(inc)) << 2;
    end else if (prod[53]) begin
      inc = prod[0] && prod[1];
      rnd = (56'(prod[54:1]) + 56'(inc)) << 1;
    end else begin
      rnd = 56'(prod);
    end
  end

  // align to the integer point, round half away from zero
  assign int_zero = ex < 8'd95;
  assign shm1     = 6'(8'd149 - ex);
  assign q        = rnd >> shm1;
  assign mag      = int_zero ? 32'd0 : (32'(q[32:1]) + 32'(q[0]));
  assign ival     = sgn ? (32'd0 - mag) : mag;

  // float64 widening, denormals normalized
  always_comb begin
    lead = '0;
    for (int i = 0; i < 23; i++) begin
      if (fr[i]) begin
        lead = 5'(i);
      end
    end
  end
  assign dn_tmp = 53'(fr) << (6'd52 - 6'(lead));
  always_comb begin
    if (ex == 8'd0) begin
      if (fr == 23'd0) begin
        f64 = {sgn, 63'd0};
      end else begin
        f64 = {sgn, 11'(lead) + asf_pkg::F64_DENORM_EXP, dn_tmp[51:0]};
      end
    end else begin
      f64 = {sgn, 11'(ex) + asf_pkg::F64_REBIAS, fr, 29'd0};
    end
  end

  // pack by format
  always_comb begin
    unique case (kind)
      asf_pkg::KIND_I16: begin
        val = {48'd0, ival[15:0]};
        cnt = 4'd2;
      end
      asf_pkg::KIND_I24: begin
        val = {40'd0, ival[23:0]};
        cnt = 4'd3;
      end
      asf_pkg::KIND_I32: begin
        val = {32'd0, ival};
        cnt = 4'd4;
      end
      asf_pkg::KIND_F32: begin
        val = {32'd0, c};
        cnt = 4'd4;
      end
      asf_pkg::KIND_F64: begin
        val = f64;
        cnt = 4'd8;
      end
      default: begin
        val = {32'd0, ival[23:0], 8'd0};
        cnt = 4'd4;
      end
    endcase
    if (unknown) begin
      result.bytes = '0;
      result.count = 4'd4;
    end else if (be) begin
      result.bytes = asf_pkg::reverse_bytes(val, cnt);
      result.count = cnt;
    end else begin
      result.bytes = val;
      result.count = cnt;
    end
  end

endmodule

@@ sv/audio_sample_formatter_unit.sv @@
`timescale 1ns / 1ps
// a sample taken into the input register is then moved to the output register
// and shown on out_valid; throughput: one sample per cycle while out_ready is
// high, with the format multiply and rounding between the two registers
// reset: synchronous active-low rst_n empties both stages and sets the
// format register to float32 little-endian
module audio_sample_formatter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count
);

  logic [3:0]  fmt_r;
  logic        s1_valid_r;
  logic [31:0] s1_bits_r;
  logic        out_valid_r;
  asf_pkg::result_t res_r;
  asf_pkg::result_t res_nxt;
  logic        adv;

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= asf_pkg::FMT_RESET;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  // stage flow control
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_bits_r <= in_sample_bits;
    end
  end

  asf_convert u_convert (
    .sample_bits   (s1_bits_r),
    .sample_format (fmt_r),
    .result        (res_nxt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bytes      = res_r.bytes;
  assign out_byte_count = res_r.count;

  // byte count is always a legal size
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == 4'd2 || out_byte_count == 4'd3 ||
                   out_byte_count == 4'd4 || out_byte_count == 4'd8))
    else $error("illegal byte count");

  // bytes above the low four are zero unless the count is eight
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_count != 4'd8) |-> (out_bytes[63:32] == 32'd0))
    else $error("nonzero bytes beyond count");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_count == 4'd2) |-> (out_bytes[63:16] == 48'd0))
    else $error("nonzero bytes beyond int16");

  // a held input stage is never dropped
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_bits_r)))
    else $error("input stage lost a transaction");

endmodule
